### src/ofdm_channel_estimate_lmmse_equalizer_core_macros.svh
// Assertion macros for the OFDM channel estimate and equalizer core.
// No dependencies; included by files that carry concurrent assertions.
`ifndef OFDM_CHANNEL_ESTIMATE_LMMSE_EQUALIZER_CORE_MACROS_SVH
`define OFDM_CHANNEL_ESTIMATE_LMMSE_EQUALIZER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define OCLE_ASSERT(name, expr) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("ocle assertion failed");
`define OCLE_ASSERT_ALWAYS(name, expr) \
   name: assert property (@(posedge clock) (expr)) \
      else $error("ocle assertion failed");
`else
`define OCLE_ASSERT(name, expr)
`define OCLE_ASSERT_ALWAYS(name, expr)
`endif
`endif

### src/ocle_pkg.sv
// Shared constants, types and register codes of the OFDM equalizer core.
// No dependencies.
`timescale 1ns / 1ps
package ocle_pkg;
   localparam int SUBCARRIERS = 64;
   localparam int PILOTS      = 4;
   localparam int ADDR_W      = (SUBCARRIERS > 1) ? $clog2(SUBCARRIERS) : 1;
   localparam int SC_W        = 6;
   localparam int SLOT_W      = 2;
   localparam int SAMPLE_W    = 16;
   localparam int H_W         = 32;
   localparam int NB_W        = 32;
   localparam int ACC_W       = 34;
   localparam int NUM_WEIGHTS = 4;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int DIV_STEPS   = 17;
   localparam int STEP_W      = $clog2(DIV_STEPS);

   localparam logic [CSR_INDEX_W-1:0] REG_PILOT_WEIGHT_0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PILOT_WEIGHT_1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PILOT_WEIGHT_2 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PILOT_WEIGHT_3 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_NOISE_BIAS     = 3'd4;
   localparam logic [NB_W-1:0]        NOISE_BIAS_RESET   = 32'd67109;

   localparam logic KIND_PILOT = 1'b0;
   localparam logic KIND_DATA  = 1'b1;

   typedef enum logic [1:0] {OP_PILOT, OP_PILOT_LAST, OP_DATA, OP_DROP} op_type;

   typedef struct packed {
      op_type                     op;
      logic [SC_W-1:0]            sc;
      logic [SLOT_W-1:0]          slot;
      logic signed [SAMPLE_W-1:0] re;
      logic signed [SAMPLE_W-1:0] im;
   } item_type;

   typedef struct packed {
      logic [NUM_WEIGHTS-1:0][SAMPLE_W-1:0] weight;
      logic [NB_W-1:0]                      noise_bias;
   } cfg_type;

   typedef struct packed {
      logic                       kind;
      logic [SC_W-1:0]            sc;
      logic signed [SAMPLE_W-1:0] re;
      logic signed [SAMPLE_W-1:0] im;
   } result_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [H_W-1:0]    wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_req_type;
endpackage

### src/ocle_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ocle_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### src/ocle_front.sv
// Input side: accepts request items, classifies them, drops invalid ones and queues the rest.
// Depends on ocle_pkg.
`timescale 1ns / 1ps
module ocle_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ocle_pkg::REQ_TDATA_W-1:0]  req_tdata, // subcarrier, pilot_slot, sample_re, sample_im
   input  logic [0:0]                        req_tuser, // kind
   output logic                              q_valid,
   input  logic                              q_ready,
   output ocle_pkg::item_type                q_item
);
   import ocle_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   cls;
   logic       push, pop;

   always_comb begin
      cls.sc   = req_tdata[5:0];
      cls.slot = req_tdata[7:6];
      cls.re   = req_tdata[23:8];
      cls.im   = req_tdata[39:24];
      if (32'(cls.sc) >= SUBCARRIERS) begin
         cls.op = OP_DROP;
      end else if (req_tuser[0] == KIND_DATA) begin
         cls.op = OP_DATA;
      end else if (32'(cls.slot) >= PILOTS) begin
         cls.op = OP_DROP;
      end else if (32'(cls.slot) == PILOTS - 1) begin
         cls.op = OP_PILOT_LAST;
      end else begin
         cls.op = OP_PILOT;
      end
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready && (cls.op != OP_DROP);
   assign q_valid    = (count_ff != 2'd0);
   assign pop        = q_valid && q_ready;
   assign q_item     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end
endmodule

### src/ocle_back.sv
// Execution side: pilot accumulation, estimate store, LMMSE division and output register.
// Depends on ocle_pkg; drives the channel store RAM.
`timescale 1ns / 1ps
module ocle_back (
   input  logic                         clock,
   input  logic                         reset,
   input  ocle_pkg::cfg_type            cfg,
   input  logic                         q_valid,
   output logic                         q_ready,
   input  ocle_pkg::item_type           q_item,
   output ocle_pkg::ram_req_type        ram_req,
   input  logic [ocle_pkg::H_W-1:0]     ram_rd_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output ocle_pkg::result_type         rsp
);
   import ocle_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_P_MUL, ST_P_ACC, ST_P_RND,
      ST_D_MUL, ST_D_SUM, ST_D_PRE, ST_D_DIV, ST_D_FIN, ST_EMIT
   } state_type;

   typedef struct packed {
      logic [33:0] rem;
      logic [16:0] low;
      logic [16:0] quo;
   } div_type;

   typedef struct packed {
      logic        neg;
      logic        over;
      logic        nil;
      div_type     div;
   } part_type;

   typedef struct packed {
      item_type           item;
      logic signed [31:0] pr;
      logic signed [31:0] pi;
      logic signed [31:0] m_rr;
      logic signed [31:0] m_ii;
      logic signed [31:0] m_ir;
      logic signed [31:0] m_ri;
      logic signed [31:0] m_hh;
      logic signed [31:0] m_gg;
      logic signed [32:0] num_re;
      logic signed [32:0] num_im;
      logic [33:0]        den;
      part_type           p_re;
      part_type           p_im;
      logic [STEP_W-1:0]  step;
      result_type         res;
   } dp_type;

   state_type                 state_ff, state_in;
   dp_type                    dp_ff, dp_in;
   logic signed [ACC_W-1:0]   acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   result_type                rsp_ff, rsp_in;

   function automatic part_type div_prep(input logic signed [32:0] num, input logic [33:0] den);
      part_type    p;
      logic [32:0] mag;
      logic [46:0] dvd;
      p.neg   = num[32];
      mag     = p.neg ? 33'($unsigned(-num)) : 33'($unsigned(num));
      dvd     = {1'b0, mag, 13'b0} + 47'(den >> 1);
      p.nil   = (mag == 33'd0);
      p.over  = (den == 34'd0) ? !p.nil : ({4'b0, dvd[46:17]} >= den);
      p.div.rem = {4'b0, dvd[46:17]};
      p.div.low = dvd[16:0];
      p.div.quo = 17'd0;
      return p;
   endfunction

   function automatic div_type div_step(input div_type d, input logic [33:0] den);
      div_type     r;
      logic [34:0] trial;
      trial = {d.rem, d.low[16]};
      r.low = {d.low[15:0], 1'b0};
      if (trial >= {1'b0, den}) begin
         r.rem = 34'(trial - {1'b0, den});
         r.quo = {d.quo[15:0], 1'b1};
      end else begin
         r.rem = trial[33:0];
         r.quo = {d.quo[15:0], 1'b0};
      end
      return r;
   endfunction

   function automatic logic signed [15:0] div_finish(input part_type p);
      logic [16:0] qc;
      if (p.nil) begin
         return 16'sd0;
      end
      qc = (p.over || p.div.quo > 17'd32768) ? 17'd32768 : p.div.quo;
      if (p.neg) begin
         return 16'(-$signed({1'b0, qc}));
      end
      return (qc >= 17'd32767) ? 16'sd32767 : 16'(qc);
   endfunction

   function automatic logic signed [15:0] round_sat(input logic signed [ACC_W-1:0] a);
      logic signed [ACC_W:0]    t;
      logic signed [ACC_W-14:0] s;
      t = ACC_W'(a) + (ACC_W+1)'(8192);
      t = $signed({a[ACC_W-1], a}) + $signed((ACC_W+1)'(8192));
      s = (ACC_W-13)'(t >>> 14);
      if (s > $signed((ACC_W-13)'(32767))) begin
         return 16'sd32767;
      end
      if (s < $signed(-(ACC_W-13)'(32768))) begin
         return -16'sd32768;
      end
      return 16'(s);
   endfunction

   logic signed [15:0] w, hr, hi;

   assign w  = $signed(cfg.weight[dp_ff.item.slot]);
   assign hr = $signed(ram_rd_data[15:0]);
   assign hi = $signed(ram_rd_data[31:16]);

   always_comb begin
      state_in     = state_ff;
      dp_in        = dp_ff;
      acc_re_in    = acc_re_ff;
      acc_im_in    = acc_im_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      q_ready      = (state_ff == ST_IDLE);
      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = ADDR_W'(dp_ff.item.sc);
      ram_req.wr_data = {dp_ff.res.im, dp_ff.res.re};
      ram_req.rd_en   = 1'b0;
      ram_req.rd_addr = ADDR_W'(q_item.sc);
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               dp_in.item = q_item;
               if (q_item.op == OP_DATA) begin
                  ram_req.rd_en = 1'b1;
                  state_in      = ST_D_MUL;
               end else begin
                  state_in = ST_P_MUL;
               end
            end
         end
         ST_P_MUL: begin
            dp_in.pr = dp_ff.item.re * w;
            dp_in.pi = dp_ff.item.im * w;
            state_in = ST_P_ACC;
         end
         ST_P_ACC: begin
            if (dp_ff.item.slot == SLOT_W'(0)) begin
               acc_re_in = ACC_W'(dp_ff.pr);
               acc_im_in = ACC_W'(dp_ff.pi);
            end else begin
               acc_re_in = acc_re_ff + ACC_W'(dp_ff.pr);
               acc_im_in = acc_im_ff + ACC_W'(dp_ff.pi);
            end
            state_in = (dp_ff.item.op == OP_PILOT_LAST) ? ST_P_RND : ST_IDLE;
         end
         ST_P_RND: begin
            dp_in.res.kind = KIND_PILOT;
            dp_in.res.sc   = dp_ff.item.sc;
            dp_in.res.re   = round_sat(acc_re_ff);
            dp_in.res.im   = round_sat(acc_im_ff);
            acc_re_in      = '0;
            acc_im_in      = '0;
            state_in       = ST_EMIT;
         end
         ST_D_MUL: begin
            dp_in.m_rr = dp_ff.item.re * hr;
            dp_in.m_ii = dp_ff.item.im * hi;
            dp_in.m_ir = dp_ff.item.im * hr;
            dp_in.m_ri = dp_ff.item.re * hi;
            dp_in.m_hh = hr * hr;
            dp_in.m_gg = hi * hi;
            state_in   = ST_D_SUM;
         end
         ST_D_SUM: begin
            dp_in.num_re = 33'(dp_ff.m_rr) + 33'(dp_ff.m_ii);
            dp_in.num_im = 33'(dp_ff.m_ir) - 33'(dp_ff.m_ri);
            dp_in.den    = 34'($unsigned(dp_ff.m_hh)) + 34'($unsigned(dp_ff.m_gg))
                         + 34'(cfg.noise_bias);
            state_in     = ST_D_PRE;
         end
         ST_D_PRE: begin
            dp_in.p_re = div_prep(dp_ff.num_re, dp_ff.den);
            dp_in.p_im = div_prep(dp_ff.num_im, dp_ff.den);
            dp_in.step = '0;
            state_in   = ST_D_DIV;
         end
         ST_D_DIV: begin
            dp_in.p_re.div = div_step(dp_ff.p_re.div, dp_ff.den);
            dp_in.p_im.div = div_step(dp_ff.p_im.div, dp_ff.den);
            dp_in.step     = dp_ff.step + STEP_W'(1);
            if (dp_ff.step == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_D_FIN;
            end
         end
         ST_D_FIN: begin
            dp_in.res.kind = KIND_DATA;
            dp_in.res.sc   = dp_ff.item.sc;
            dp_in.res.re   = div_finish(dp_ff.p_re);
            dp_in.res.im   = div_finish(dp_ff.p_im);
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               if (dp_ff.res.kind == KIND_PILOT) begin
                  ram_req.wr_en = 1'b1;
               end
               rsp_in       = dp_ff.res;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         acc_re_ff    <= '0;
         acc_im_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_re_ff    <= acc_re_in;
         acc_im_ff    <= acc_im_in;
      end
      dp_ff  <= dp_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
endmodule

### src/ofdm_channel_estimate_lmmse_equalizer_core.sv
// Top level of the OFDM pilot channel estimator and LMMSE equalizer.
// Depends on ocle_pkg, ocle_front, ocle_back, ocle_ram and the assertion macro header.
//
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  tdata: subcarrier, pilot_slot, sample_re, sample_im; tuser: kind
// rsp      out  rsp_tvalid/rsp_tready  tdata: result_subcarrier, value_re, value_im; tuser: result_kind
// csr      in   csr_valid/csr_ready    csr_index, csr_data
//
// A pilot is multiplied and accumulated in the back end; the last pilot of a subcarrier is also rounded and stored.
// A data item is multiplied, summed and divided by two 17-step restoring dividers, one per part.
// A two-entry queue behind the input lets requests land while the back end works.
// Reset is synchronous; the channel store is not cleared and needs no pass.
// A stalled result holds in the output register; the back end waits, the queue keeps filling.
`timescale 1ns / 1ps
`include "ofdm_channel_estimate_lmmse_equalizer_core_macros.svh"
module ofdm_channel_estimate_lmmse_equalizer_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ocle_pkg::REQ_TDATA_W-1:0]  req_tdata, // subcarrier, pilot_slot, sample_re, sample_im
   input  logic [0:0]                        req_tuser, // kind
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ocle_pkg::RSP_TDATA_W-1:0]  rsp_tdata, // result_subcarrier, value_re, value_im, zero pad
   output logic [0:0]                        rsp_tuser, // result_kind
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ocle_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ocle_pkg::CSR_DATA_W-1:0]   csr_data
);
   import ocle_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   logic        q_valid, q_ready;
   item_type    q_item;
   ram_req_type ram_req;
   logic [H_W-1:0] ram_rd_data;
   result_type  rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_PILOT_WEIGHT_0: cfg_in.weight[0]  = csr_data[15:0];
            REG_PILOT_WEIGHT_1: cfg_in.weight[1]  = csr_data[15:0];
            REG_PILOT_WEIGHT_2: cfg_in.weight[2]  = csr_data[15:0];
            REG_PILOT_WEIGHT_3: cfg_in.weight[3]  = csr_data[15:0];
            REG_NOISE_BIAS:     cfg_in.noise_bias = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.weight     <= '0;
         cfg_ff.noise_bias <= NOISE_BIAS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ocle_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_item     (q_item)
   );

   ocle_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_item      (q_item),
      .ram_req     (ram_req),
      .ram_rd_data (ram_rd_data),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp         (rsp)
   );

   ocle_ram #(
      .WIDTH  (H_W),
      .DEPTH  (SUBCARRIERS),
      .ADDR_W (ADDR_W)
   ) u_channel_store (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_tdata = {2'b00, rsp.im, rsp.re, rsp.sc};
   assign rsp_tuser = rsp.kind;

   `OCLE_ASSERT(a_queue_hold, q_valid && !q_ready |=> q_valid)
   `OCLE_ASSERT(a_no_drop_queued, q_valid |-> q_item.op != OP_DROP)
   `OCLE_ASSERT_ALWAYS(a_rsp_reset, reset |=> !rsp_tvalid)
endmodule

### verif/tb.sv
// Self-checking testbench for the OFDM pilot channel estimator and LMMSE equalizer core.
// Needs ocle_pkg and the core; a built-in predictor forms the expected items,
// and directed plus random streams run, most of them under random back-pressure.
`timescale 1ns / 1ps
module tb;
   import ocle_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0; // subcarrier, pilot_slot, sample_re, sample_im
   logic [0:0]             req_tuser = '0; // kind
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;      // result_subcarrier, value_re, value_im, zero pad
   logic [0:0]             rsp_tuser;      // result_kind
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   ofdm_channel_estimate_lmmse_equalizer_core dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // predictor state
   logic signed [15:0] slot_weight [4];
   logic [31:0]        bias_term;
   logic signed [15:0] est_re [SUBCARRIERS];
   logic signed [15:0] est_im [SUBCARRIERS];
   logic signed [33:0] sum_re, sum_im;

   result_type expected_items [$];
   bit  est_known [SUBCARRIERS];
   bit  idle_en = 1'b1;
   int  hold_cycles = 0;
   int  burst_left = 0;
   int  gap_left = 0;
   int  mismatches = 0;
   int  items_sent = 0;
   int  results_seen = 0;
   int  quiet_cycles = 0;

   function automatic longint sat16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint equalize_part(longint num, longint unsigned den);
      longint unsigned mag, q;
      if (den == 0) begin
         if (num > 0) return 32767;
         if (num < 0) return -32768;
         return 0;
      end
      mag = longint'(num < 0 ? -num : num) << 13;
      q = (mag + den / 2) / den;
      if (q > 32768) q = 32768;
      return sat16(num < 0 ? -longint'(q) : longint'(q));
   endfunction

   task automatic predict_item(logic kind, logic [5:0] sc, logic [1:0] slot,
                               logic signed [15:0] sr, logic signed [15:0] si);
      result_type r;
      longint pr, pi, hr, hi, den;
      pr = longint'(sr) * longint'(slot_weight[slot]);
      pi = longint'(si) * longint'(slot_weight[slot]);
      hr = longint'(est_re[sc]);
      hi = longint'(est_im[sc]);
      r.kind = kind;
      r.sc = sc;
      if (kind == KIND_PILOT) begin
         if (slot == 0) begin
            sum_re = pr[33:0];
            sum_im = pi[33:0];
         end else begin
            sum_re = sum_re + pr[33:0];
            sum_im = sum_im + pi[33:0];
         end
         if (slot != PILOTS - 1) return;
         r.re = 16'(sat16((longint'(sum_re) + 8192) >>> 14));
         r.im = 16'(sat16((longint'(sum_im) + 8192) >>> 14));
         est_re[sc] = r.re;
         est_im[sc] = r.im;
         sum_re = '0;
         sum_im = '0;
      end else begin
         den = hr * hr + hi * hi + longint'(bias_term);
         r.re = 16'(equalize_part(longint'(sr) * hr + longint'(si) * hi, den));
         r.im = 16'(equalize_part(longint'(si) * hr - longint'(sr) * hi, den));
      end
      expected_items.push_back(r);
   endtask

   // accepted items, configuration writes and results
   always @(posedge clock) begin
      result_type want;
      logic signed [15:0] got_re, got_im;
      if (reset) begin
         for (int i = 0; i < 4; i++) slot_weight[i] = '0;
         bias_term = NOISE_BIAS_RESET;
         sum_re = '0;
         sum_im = '0;
         for (int i = 0; i < SUBCARRIERS; i++) begin
            est_re[i] = '0;
            est_im[i] = '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_NOISE_BIAS) bias_term = csr_data;
            else if (csr_index <= REG_PILOT_WEIGHT_3)
               slot_weight[csr_index[1:0]] = csr_data[15:0];
         end
         if (req_tvalid && req_tready)
            predict_item(req_tuser[0], req_tdata[5:0], req_tdata[7:6],
                         req_tdata[23:8], req_tdata[39:24]);
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            got_re = rsp_tdata[21:6];
            got_im = rsp_tdata[37:22];
            if (expected_items.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result sc=%0d", rsp_tdata[5:0]);
            end else begin
               want = expected_items.pop_front();
               if (want.kind !== rsp_tuser[0] || want.sc !== rsp_tdata[5:0] ||
                   want.re !== got_re || want.im !== got_im) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch exp kind=%0d sc=%0d re=%0d im=%0d",
                               " got kind=%0d sc=%0d re=%0d im=%0d"},
                              want.kind, want.sc, want.re, want.im,
                              rsp_tuser[0], rsp_tdata[5:0], got_re, got_im);
               end
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   // result side readiness
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_tready = 1'b0;
      end else if (burst_left > 0) begin
         burst_left--;
         rsp_tready = 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
         burst_left = $urandom_range(0, 8);
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   task automatic send_item(logic kind, logic [5:0] sc, logic [1:0] slot,
                            logic [15:0] sr, logic [15:0] si);
      if (idle_en && $urandom_range(0, 4) == 0) begin
         gap_left = $urandom_range(1, 9);
         req_tvalid = 1'b0;
         repeat (gap_left) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = kind;
      req_tdata = {si, sr, slot, sc};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid = 1'b0;
      items_sent++;
      if (kind == KIND_PILOT && slot == PILOTS - 1) est_known[sc] = 1'b1;
   endtask

   task automatic drain_results();
      while (expected_items.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [31:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_weights(logic [15:0] w0, logic [15:0] w1, logic [15:0] w2,
                              logic [15:0] w3, logic [31:0] bias);
      drain_results();
      write_reg(REG_PILOT_WEIGHT_0, {16'h0, w0});
      write_reg(REG_PILOT_WEIGHT_1, {16'h0, w1});
      write_reg(REG_PILOT_WEIGHT_2, {16'h0, w2});
      write_reg(REG_PILOT_WEIGHT_3, {16'h0, w3});
      write_reg(REG_NOISE_BIAS, bias);
   endtask

   task automatic send_pilots(logic [5:0] sc, logic [15:0] sr, logic [15:0] si);
      for (int s = 0; s < PILOTS; s++) send_item(KIND_PILOT, sc, s[1:0], sr, si);
   endtask

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'($urandom_range(0, 15) - 8);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_stream(int n);
      int sent;
      logic [5:0] sc;
      sent = 0;
      while (sent < n) begin
         sc = 6'($urandom_range(0, SUBCARRIERS - 1));
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5: begin
               for (int s = 0; s < PILOTS; s++)
                  send_item(KIND_PILOT, sc, s[1:0], pick_sample(), pick_sample());
               sent += PILOTS;
            end
            6: begin
               send_item(KIND_PILOT, sc, 2'($urandom), pick_sample(), pick_sample());
               sent++;
            end
            default: begin
               if (est_known[sc]) begin
                  send_item(KIND_DATA, sc, 2'($urandom), pick_sample(), pick_sample());
                  sent++;
               end
            end
         endcase
      end
   endtask

   task automatic test_reset_values();
      send_pilots(6'd0, 16'h7FFF, 16'h8000);
      send_item(KIND_DATA, 6'd0, 2'd0, 16'h7FFF, 16'h8000);
      send_item(KIND_DATA, 6'd0, 2'd3, 16'h0000, 16'h0001);
   endtask

   task automatic test_extremes();
      set_weights(16'h7FFF, 16'h8000, 16'h4000, 16'h7FFF, 32'd0);
      send_pilots(6'd63, 16'h7FFF, 16'h8000);
      send_pilots(6'd1, 16'h8000, 16'h8000);
      send_item(KIND_DATA, 6'd63, 2'd1, 16'h8000, 16'h7FFF);
      send_item(KIND_DATA, 6'd1, 2'd2, 16'h7FFF, 16'h7FFF);
      set_weights(16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'd0);
      send_pilots(6'd2, 16'h8000, 16'h7FFF);
      send_item(KIND_DATA, 6'd2, 2'd0, 16'h0001, 16'hFFFF);
   endtask

   task automatic test_zero_divisor();
      set_weights(16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'd0);
      send_pilots(6'd3, 16'h1234, 16'h8000);
      send_item(KIND_DATA, 6'd3, 2'd0, 16'h0005, 16'h0000);
      send_item(KIND_DATA, 6'd3, 2'd0, 16'h8000, 16'h0000);
      send_item(KIND_DATA, 6'd3, 2'd0, 16'h0000, 16'h0000);
      set_weights(16'h0001, 16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
      send_pilots(6'd4, 16'h7FFF, 16'h0001);
      send_item(KIND_DATA, 6'd4, 2'd0, 16'h7FFF, 16'h8000);
   endtask

   task automatic test_random_settings();
      for (int k = 0; k < 6; k++) begin
         if (k % 2 == 0)
            set_weights(16'd4096, 16'd4096, 16'd4096, 16'd4096, $urandom_range(0, 200000));
         else
            set_weights(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
         random_stream(250);
      end
   endtask

   task automatic test_backpressure();
      drain_results();
      hold_cycles = 400;
      for (int i = 0; i < 12; i++) send_pilots(6'(i), pick_sample(), pick_sample());
   endtask

   task automatic test_no_idle();
      idle_en = 1'b0;
      set_weights(16'h7FFF, 16'd8192, 16'hC000, 16'd4096, 32'h0400_0000);
      random_stream(250);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_values();
      test_extremes();
      test_zero_divisor();
      test_random_settings();
      test_backpressure();
      test_no_idle();
      drain_results();
      $display("covered %0d items and %0d results over several weight and bias settings,",
               items_sent, results_seen);
      $display("including zero divisor, saturation and a long result stall");
      if (mismatches == 0 && expected_items.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end
endmodule
